>>> sv/sc2_pkg.sv
// Shared types, round constants and sigma functions for the SHACAL-2 encrypt unit.
package sc2_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned KEY_REGS  = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SCHED_MAX = 64;
  localparam int unsigned WIN_LEN   = 16;
  localparam int unsigned RIDX_W    = 6;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
    word_t f;
    word_t g;
    word_t h;
  } work_t;

  typedef struct packed {
    logic load;
    logic step;
  } sched_ctl_t;

  localparam word_t RC [SCHED_MAX] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

endpackage

>>> sv/sc2_sched.sv
// Key schedule: 16-word sliding window expanded one word per round.
module sc2_sched
  import sc2_pkg::*;
(
  input  logic                       clk,
  input  sched_ctl_t                 ctl,
  input  word_t [KEY_REGS*2-1:0]     key_words,
  output word_t                      w_cur
);

  word_t win_r [WIN_LEN];
  word_t w_new;

  assign w_new = small_sigma1(win_r[14]) + win_r[9] + small_sigma0(win_r[1]) + win_r[0];
  assign w_cur = win_r[0];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= key_words[i];
      end
    end else if (ctl.step) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WIN_LEN-1] <= w_new;
    end
  end

endmodule

>>> sv/sc2_round.sv
// One SHA-256 compression round, combinational.
module sc2_round
  import sc2_pkg::*;
(
  input  work_t cur,
  input  word_t w,
  input  word_t k,
  output work_t nxt
);

  word_t ch;
  word_t maj;
  word_t t1;
  word_t t2;

  always_comb begin
    ch  = (cur.e & cur.f) ^ (~cur.e & cur.g);
    maj = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
    t1  = cur.h + big_sigma1(cur.e) + ch + w + k;
    t2  = big_sigma0(cur.a) + maj;
    nxt.h = cur.g;
    nxt.g = cur.f;
    nxt.f = cur.e;
    nxt.e = cur.d + t1;
    nxt.d = cur.c;
    nxt.c = cur.b;
    nxt.b = cur.a;
    nxt.a = t1 + t2;
  end

endmodule

>>> sv/shacal2_block_encrypt_unit.sv
// SHACAL-2 encrypt unit top level: key registers, round sequencer and state.
//
// Encrypts one 256-bit block per item under the 512-bit key held in the eight
// cfg registers (index i holds key words 2i and 2i+1, big-endian). An item
// takes a load in ST_IDLE, ROUND_COUNT rounds (capped at 64) in ST_RUN, and ST_DONE,
// where the result is presented until out_ready takes it. The single round
// unit and the 16-word schedule window advance once per cycle in ST_RUN; one
// block is in flight at a time and in_ready is low until the result is taken.
// Key registers reset to zero and should be written only while the unit is
// idle.
module shacal2_block_encrypt_unit
  import sc2_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [63:0]          in_plain_words_0_1,
  input  logic [63:0]          in_plain_words_2_3,
  input  logic [63:0]          in_plain_words_4_5,
  input  logic [63:0]          in_plain_words_6_7,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          out_cipher_words_0_1,
  output logic [63:0]          out_cipher_words_2_3,
  output logic [63:0]          out_cipher_words_4_5,
  output logic [63:0]          out_cipher_words_6_7
);

  localparam int unsigned ROUNDS = (ROUND_COUNT > SCHED_MAX) ? SCHED_MAX : ROUND_COUNT;
  localparam logic [RIDX_W-1:0] LAST_RND = RIDX_W'(ROUNDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [RIDX_W-1:0]   rnd_r, rnd_nxt;
  logic [63:0]         key_r [KEY_REGS];
  word_t [KEY_REGS*2-1:0] key_words;
  work_t               work_r, work_nxt, round_out;
  word_t               w_cur;
  sched_ctl_t          sched_ctl;
  logic                in_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign in_fire   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_REGS; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_REGS; i++) begin
      key_words[2*i]   = key_r[i][63:32];
      key_words[2*i+1] = key_r[i][31:0];
    end
  end

  always_comb begin
    sched_ctl.load = in_fire;
    sched_ctl.step = (state_r == ST_RUN);
  end

  sc2_sched u_sched (
    .clk       (clk),
    .ctl       (sched_ctl),
    .key_words (key_words),
    .w_cur     (w_cur)
  );

  sc2_round u_round (
    .cur (work_r),
    .w   (w_cur),
    .k   (RC[rnd_r]),
    .nxt (round_out)
  );

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    work_nxt  = work_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          work_nxt = {in_plain_words_0_1, in_plain_words_2_3,
                      in_plain_words_4_5, in_plain_words_6_7};
          rnd_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        work_nxt = round_out;
        rnd_nxt  = rnd_r + 1'b1;
        if (rnd_r == LAST_RND) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  assign out_cipher_words_0_1 = {work_r.a, work_r.b};
  assign out_cipher_words_2_3 = {work_r.c, work_r.d};
  assign out_cipher_words_4_5 = {work_r.e, work_r.f};
  assign out_cipher_words_6_7 = {work_r.g, work_r.h};

endmodule

>>> test/shacal2_encrypt_checker.sv
// Watches the key port and both beat channels, predicts each ciphertext and compares it.
`timescale 1ns / 100ps
module shacal2_encrypt_checker
  import sc2_pkg::*;
#(
  parameter int unsigned ROUNDS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [63:0]          in_plain_words_0_1,
  input  logic [63:0]          in_plain_words_2_3,
  input  logic [63:0]          in_plain_words_4_5,
  input  logic [63:0]          in_plain_words_6_7,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [63:0]          out_cipher_words_0_1,
  input  logic [63:0]          out_cipher_words_2_3,
  input  logic [63:0]          out_cipher_words_4_5,
  input  logic [63:0]          out_cipher_words_6_7,
  output int unsigned          fail_count,
  output int unsigned          pending
);

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam int unsigned RUN_ROUNDS = (ROUNDS > 64) ? 64 : ROUNDS;

  logic [511:0] key_bits;
  logic [255:0] cipher_q [$];
  logic [255:0] got_block;
  logic [255:0] want_block;
  int unsigned  mismatches = 0;
  int unsigned  outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  function automatic word_t ror(input word_t v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t sum0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t sum1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t mix0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t mix1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  // Key word j sits at bits 511-32j; working variable a at the top of the block.
  function automatic logic [255:0] shacal2_encrypt(input logic [511:0] key,
                                                   input logic [255:0] plain);
    word_t sched [64];
    work_t v;
    word_t ch;
    word_t maj;
    word_t t1;
    word_t t2;
    for (int i = 0; i < 16; i++) sched[i] = key[511 - 32*i -: 32];
    for (int i = 16; i < 64; i++)
      sched[i] = mix1(sched[i-2]) + sched[i-7] + mix0(sched[i-15]) + sched[i-16];
    v = plain;
    for (int i = 0; i < RUN_ROUNDS; i++) begin
      ch  = (v.e & v.f) ^ (~v.e & v.g);
      maj = (v.a & v.b) ^ (v.a & v.c) ^ (v.b & v.c);
      t1  = v.h + sum1(v.e) + ch + sched[i] + ROUND_K[i];
      t2  = sum0(v.a) + maj;
      v   = {word_t'(t1 + t2), v.a, v.b, v.c, word_t'(v.d + t1), v.e, v.f, v.g};
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      key_bits <= '0;
    end else begin
      if (cfg_we) key_bits[511 - 64*cfg_index -: 64] <= cfg_data;
      // retire before queueing: a beat out can never belong to the beat coming in
      if (out_valid && out_ready) begin
        got_block = {out_cipher_words_0_1, out_cipher_words_2_3,
                     out_cipher_words_4_5, out_cipher_words_6_7};
        if (cipher_q.size() == 0) begin
          $error("result beat with nothing expected: %h", got_block);
          mismatches++;
        end else begin
          want_block = cipher_q.pop_front();
          for (int f = 0; f < 4; f++) begin
            if (got_block[255 - 64*f -: 64] !== want_block[255 - 64*f -: 64]) begin
              $error("cipher_words_%0d_%0d mismatch: expected %h, got %h", 2*f, 2*f + 1,
                     want_block[255 - 64*f -: 64], got_block[255 - 64*f -: 64]);
              mismatches++;
            end
          end
        end
      end
      if (in_valid && in_ready)
        cipher_q.push_back(shacal2_encrypt(key_bits,
          {in_plain_words_0_1, in_plain_words_2_3, in_plain_words_4_5, in_plain_words_6_7}));
    end
    outstanding <= cipher_q.size();
  end

endmodule

>>> test/tb.sv
// Top-level bench for the SHACAL-2 encrypt unit: clock, reset, key loads and block traffic.
`timescale 1ns / 100ps
module tb;
  import sc2_pkg::*;

  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [63:0]          in_plain_words_0_1;
  logic [63:0]          in_plain_words_2_3;
  logic [63:0]          in_plain_words_4_5;
  logic [63:0]          in_plain_words_6_7;
  logic                 out_valid;
  logic                 out_ready;
  logic [63:0]          out_cipher_words_0_1;
  logic [63:0]          out_cipher_words_2_3;
  logic [63:0]          out_cipher_words_4_5;
  logic [63:0]          out_cipher_words_6_7;
  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          send_idle_pct = 26;
  int unsigned          recv_idle_pct = 63;
  int unsigned          cycle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  shacal2_block_encrypt_unit #(.ROUND_COUNT(ROUNDS)) dut (.*);

  shacal2_encrypt_checker #(.ROUNDS(ROUNDS)) chk (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: stall at random, redrawn every cycle
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic logic [63:0] rand_field();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [255:0] rand_block();
    return {rand_field(), rand_field(), rand_field(), rand_field()};
  endfunction

  function automatic logic [511:0] rand_key();
    logic [511:0] k;
    for (int i = 0; i < KEY_REGS; i++) k[511 - 64*i -: 64] = rand_field();
    return k;
  endfunction

  // Writes each key register with the given odds; only called with the unit idle.
  task automatic load_key(input logic [511:0] k, input int unsigned write_pct);
    for (int i = 0; i < KEY_REGS; i++) begin
      if ($urandom_range(0, 99) < write_pct) begin
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = i[CFG_IDX_W-1:0];
        cfg_data  = k[511 - 64*i -: 64];
        @(posedge clk);
      end
    end
    @(negedge clk);
    cfg_we = 1'b0;
    @(posedge clk);
  endtask

  // Returns right after the posedge that accepts the beat; valid stays up.
  task automatic push_block(input logic [255:0] plain);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    {in_plain_words_0_1, in_plain_words_2_3, in_plain_words_4_5, in_plain_words_6_7} = plain;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [511:0] key;
    int unsigned  sel;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    {in_plain_words_0_1, in_plain_words_2_3, in_plain_words_4_5, in_plain_words_6_7} = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // all-zero key straight out of reset
    push_block('0);
    push_block('1);
    push_block({32{8'haa}});
    push_block({32{8'h55}});
    settle();

    load_key('1, 100);
    push_block('0);
    push_block('1);
    push_block(256'h1);
    push_block({1'b1, 255'h0});
    settle();

    load_key({8{64'h8000_0001_0123_4567}}, 100);
    push_block({64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'hf0e1d2c3b4a59687, 64'h7fffffff80000000});
    push_block(rand_block());
    push_block(rand_block());
    push_block(rand_block());
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 26; recv_idle_pct = 63; end
        1: begin send_idle_pct = 63; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int chunk = 0; chunk < 6; chunk++) begin
        sel = $urandom_range(0, 7);
        if (sel == 0) load_key('0, 100);
        else if (sel == 1) load_key('1, 100);
        else begin
          // partial reloads keep some old key words in place
          key = rand_key();
          load_key(key, 75);
        end
        repeat (52) push_block(rand_block());
        settle();
      end
    end

    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
sv/sc2_pkg.sv
sv/sc2_sched.sv
sv/sc2_round.sv
sv/shacal2_block_encrypt_unit.sv
test/shacal2_encrypt_checker.sv
test/tb.sv
